// ===== hw/rtl/acss_pkg.sv =====
package acss_pkg;

    // Fixed field widths of the transaction ports
    localparam int OPCODE_W  = 2;
    localparam int CHANNEL_W = 4;
    localparam int SAMPLE_W  = 12;

    typedef enum logic [OPCODE_W-1:0] {
        OP_REQUEST = 2'd0,
        OP_DONE    = 2'd1,
        OP_QUERY   = 2'd2,
        OP_READ    = 2'd3
    } opcode_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;   // capture the input transaction
        logic exec;   // apply the update and load the result register
    } cmd_t;

endpackage

// ===== hw/rtl/acss_ctrl.sv =====
module acss_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  logic            m_ready,
    output acss_pkg::cmd_t  cmd
);
    import acss_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.exec   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // hold until the result register can take the new result
                if (out_free) begin
                    cmd.exec   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.exec) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    a_exec_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec |-> (!m_valid_reg || m_ready))
        else $error("result loaded over an untaken result");

    a_exec_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec |=> m_valid_reg)
        else $error("result register not marked valid after execute");

    a_load_then_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> (state_reg == ST_EXEC && !s_ready))
        else $error("captured transaction not held for execute");

endmodule

// ===== hw/rtl/acss_dpath.sv =====
module acss_dpath #(
    parameter int NUM_CHANNELS = 16,
    parameter int SAMPLE_BITS  = 12,
    parameter int COUNT_BITS   = 4
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  acss_pkg::cmd_t                     cmd,
    input  logic [acss_pkg::OPCODE_W-1:0]      s_opcode,
    input  logic [acss_pkg::CHANNEL_W-1:0]     s_channel,
    input  logic                               s_continuous,
    input  logic [acss_pkg::SAMPLE_W-1:0]      s_sample_value,
    output logic [acss_pkg::CHANNEL_W-1:0]     m_selected_channel,
    output logic                               m_converting,
    output logic                               m_done_flag,
    output logic [acss_pkg::SAMPLE_W-1:0]      m_stored_sample
);
    import acss_pkg::*;

    localparam int CH_BITS    = $clog2(NUM_CHANNELS);
    localparam int STORE_BITS = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;

    // captured transaction
    opcode_t                 op_reg;
    logic [CHANNEL_W-1:0]    ch_reg;
    logic                    cont_reg;
    logic [STORE_BITS-1:0]   smp_reg;

    // per-channel tables
    logic                    mark_reg  [NUM_CHANNELS];
    logic                    mark_next [NUM_CHANNELS];
    logic [COUNT_BITS-1:0]   count_reg [NUM_CHANNELS];
    logic [COUNT_BITS-1:0]   count_next[NUM_CHANNELS];
    logic                    flag_reg  [NUM_CHANNELS];
    logic                    flag_next [NUM_CHANNELS];
    logic [STORE_BITS-1:0]   store_reg [NUM_CHANNELS];

    logic [CH_BITS-1:0]      cur_reg, cur_next;
    logic                    run_reg, run_next;

    // result register
    logic [CHANNEL_W-1:0]    sel_out_reg;
    logic                    conv_out_reg;
    logic                    flag_out_reg;
    logic [SAMPLE_W-1:0]     smp_out_reg;

    logic                    ch_ok;
    logic [CH_BITS-1:0]      idx;
    logic                    is_req, is_done, is_query, is_read;
    logic [NUM_CHANNELS-1:0] eligible, masked, pick_src, grant;
    logic [CH_BITS-1:0]      grant_idx;
    logic                    found;

    assign ch_ok    = (int'(ch_reg) < NUM_CHANNELS);
    assign idx      = CH_BITS'(ch_reg);
    assign is_req   = (op_reg == OP_REQUEST) && ch_ok;
    assign is_done  = (op_reg == OP_DONE) && run_reg;
    assign is_query = (op_reg == OP_QUERY) && ch_ok;
    assign is_read  = (op_reg == OP_READ) && ch_ok;

    // rotating priority: channels above the current one first, current one last
    always_comb begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            eligible[i] = mark_reg[i] || (count_reg[i] != '0);
            masked[i]   = eligible[i] && (CH_BITS'(i) > cur_reg);
        end
    end

    assign found    = |eligible;
    assign pick_src = (|masked) ? masked : eligible;
    assign grant    = pick_src & (~pick_src + NUM_CHANNELS'(1));

    always_comb begin
        grant_idx = '0;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            if (grant[i]) begin
                grant_idx = grant_idx | CH_BITS'(i);
            end
        end
    end

    // per-channel next state, each lane sees only its own entry
    always_comb begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            mark_next[i]  = mark_reg[i];
            count_next[i] = count_reg[i];
            flag_next[i]  = flag_reg[i];
            if (is_req && idx == CH_BITS'(i)) begin
                if (cont_reg) begin
                    mark_next[i]  = 1'b1;
                    count_next[i] = '0;
                end else if (mark_reg[i]) begin
                    mark_next[i]  = 1'b0;
                    count_next[i] = COUNT_BITS'(1);
                end else if (count_reg[i] != '1) begin
                    count_next[i] = count_reg[i] + COUNT_BITS'(1);
                end
            end
            if (is_done && grant[i] && !mark_reg[i]) begin
                count_next[i] = count_reg[i] - COUNT_BITS'(1);
            end
            if (is_done && cur_reg == CH_BITS'(i)) begin
                flag_next[i] = 1'b1;
            end
            if (is_query && idx == CH_BITS'(i)) begin
                flag_next[i] = 1'b0;
            end
        end
    end

    always_comb begin
        cur_next = cur_reg;
        run_next = run_reg;
        if (is_req) begin
            cur_next = idx;
            run_next = 1'b1;
        end else if (is_done) begin
            if (found) begin
                cur_next = grant_idx;
            end
            run_next = found;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= opcode_t'(s_opcode);
            ch_reg   <= s_channel;
            cont_reg <= s_continuous;
            smp_reg  <= STORE_BITS'(s_sample_value);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                mark_reg[i]  <= 1'b0;
                count_reg[i] <= '0;
                flag_reg[i]  <= 1'b0;
                store_reg[i] <= '0;
            end
            cur_reg <= '0;
            run_reg <= 1'b0;
        end else if (cmd.exec) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                mark_reg[i]  <= mark_next[i];
                count_reg[i] <= count_next[i];
                flag_reg[i]  <= flag_next[i];
            end
            if (is_done) begin
                store_reg[cur_reg] <= smp_reg;
            end
            cur_reg <= cur_next;
            run_reg <= run_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            sel_out_reg  <= CHANNEL_W'(cur_next);
            conv_out_reg <= run_next;
            flag_out_reg <= is_query ? flag_reg[idx] : 1'b0;
            smp_out_reg  <= is_read ? SAMPLE_W'(store_reg[idx]) : '0;
        end
    end

    assign m_selected_channel = sel_out_reg;
    assign m_converting       = conv_out_reg;
    assign m_done_flag        = flag_out_reg;
    assign m_stored_sample    = smp_out_reg;

    a_grant_onehot0: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(grant))
        else $error("round-robin grant has more than one channel");

    a_request_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.exec && is_req) |=> run_reg)
        else $error("request did not start the converter");

    a_empty_search_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.exec && is_done && !found) |=> !run_reg)
        else $error("converter kept running with no eligible channel");

endmodule

// ===== hw/rtl/adc_channel_scan_sequencer.sv =====
// Round-robin conversion scheduler for NUM_CHANNELS converter channels. Each
// input transaction carries one command: a channel request (continuous, or one
// more single conversion, saturating at 2^COUNT_BITS-1), a conversion-done
// event with its sample, a read-and-clear of a channel's done flag, or a
// sample read. Every transaction yields exactly one result transaction with
// the selected channel and running state after the command, plus the flag or
// sample that was asked for (zero otherwise). A transaction is first captured,
// then the controller issues the execute step that applies the update, the
// rotating priority search over the channel table and the result load. The
// execute step waits only while the output register still holds an untaken
// result; the next transaction is not accepted until the execute step is
// done. Channels at or beyond NUM_CHANNELS are ignored by requests and read
// back as zero. The first conversion after a request consumes no count.
// Reset clears all per-channel tables at once; there is no clearing pass.
module adc_channel_scan_sequencer #(
    parameter int NUM_CHANNELS = 16,
    parameter int SAMPLE_BITS  = 12,
    parameter int COUNT_BITS   = 4
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [acss_pkg::OPCODE_W-1:0]      s_opcode,
    input  logic [acss_pkg::CHANNEL_W-1:0]     s_channel,
    input  logic                               s_continuous,
    input  logic [acss_pkg::SAMPLE_W-1:0]      s_sample_value,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [acss_pkg::CHANNEL_W-1:0]     m_selected_channel,
    output logic                               m_converting,
    output logic                               m_done_flag,
    output logic [acss_pkg::SAMPLE_W-1:0]      m_stored_sample
);
    import acss_pkg::*;

    cmd_t cmd;

    // Sequence capture and execute, and own the result handshake
    acss_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // Channel tables, round-robin search and result register
    acss_dpath #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .SAMPLE_BITS  (SAMPLE_BITS),
        .COUNT_BITS   (COUNT_BITS)
    ) u_dpath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .s_opcode           (s_opcode),
        .s_channel          (s_channel),
        .s_continuous       (s_continuous),
        .s_sample_value     (s_sample_value),
        .m_selected_channel (m_selected_channel),
        .m_converting       (m_converting),
        .m_done_flag        (m_done_flag),
        .m_stored_sample    (m_stored_sample)
    );

endmodule

// ===== dv/adc_channel_scan_sequencer_tb.sv =====
`timescale 1ns / 1ps

module adc_channel_scan_sequencer_tb;

    import acss_pkg::*;

    localparam int          NUM_CH      = 16;
    localparam logic [3:0]  COUNT_MAX   = 4'hF;
    localparam int          RAND_ITEMS  = 700;
    localparam int          DRAIN_CYCLES = 20;
    localparam int          CYCLE_LIMIT = 300000;
    localparam int          HOLD_CYCLES = 300;

    // One result transaction as the block reports it
    typedef struct packed {
        logic [CHANNEL_W-1:0] sel;
        logic                 conv;
        logic                 flag;
        logic [SAMPLE_W-1:0]  sample;
    } scan_status_t;

    // Directed stimulus row; rows marked typed carry a hand-written result
    typedef struct {
        opcode_t              op;
        logic [CHANNEL_W-1:0] ch;
        logic                 cont;
        logic [SAMPLE_W-1:0]  samp;
        int                   reps;
        bit                   typed;
        scan_status_t         res;
    } scan_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [OPCODE_W-1:0]   s_opcode;
    logic [CHANNEL_W-1:0]  s_channel;
    logic                  s_continuous;
    logic [SAMPLE_W-1:0]   s_sample_value;
    logic                  m_valid;
    logic                  m_ready;
    logic [CHANNEL_W-1:0]  m_selected_channel;
    logic                  m_converting;
    logic                  m_done_flag;
    logic [SAMPLE_W-1:0]   m_stored_sample;

    // Side-band of the driver: hand-written result travelling with the payload
    bit                    drv_typed;
    scan_status_t          drv_res;

    // Predictor state, mirrors the block's channel tables
    logic [SAMPLE_W-1:0]   mdl_samples [NUM_CH];
    logic                  mdl_flags   [NUM_CH];
    logic [3:0]            mdl_count   [NUM_CH];
    logic                  mdl_cont    [NUM_CH];
    logic [CHANNEL_W-1:0]  mdl_cur;
    logic                  mdl_run;

    scan_status_t          scan_status_q [$];
    scan_row_t             scan_rows [$];
    int                    mismatches      = 0;
    int                    effective_items = 0;
    int                    burst_left      = 0;

    always #5 aclk = ~aclk;

    adc_channel_scan_sequencer DUT (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_opcode           (s_opcode),
        .s_channel          (s_channel),
        .s_continuous       (s_continuous),
        .s_sample_value     (s_sample_value),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_selected_channel (m_selected_channel),
        .m_converting       (m_converting),
        .m_done_flag        (m_done_flag),
        .m_stored_sample    (m_stored_sample)
    );

    // Advance the scheduler by one command and return the status it reports.
    function automatic scan_status_t predict_scan(opcode_t op, logic [CHANNEL_W-1:0] ch,
                                                  logic cont, logic [SAMPLE_W-1:0] samp);
        scan_status_t         r;
        logic [CHANNEL_W-1:0] c;
        bit                   found;
        r = '0;
        case (op)
            OP_REQUEST: begin
                // Continuous clears the count; single on a continuous channel
                // drops the mark and leaves exactly one conversion pending.
                if (cont) begin
                    mdl_cont[ch]  = 1'b1;
                    mdl_count[ch] = '0;
                end else if (mdl_cont[ch]) begin
                    mdl_cont[ch]  = 1'b0;
                    mdl_count[ch] = 4'd1;
                end else if (mdl_count[ch] != COUNT_MAX) begin
                    mdl_count[ch] = mdl_count[ch] + 4'd1;
                end
                mdl_cur = ch;
                mdl_run = 1'b1;
            end
            OP_DONE: begin
                // A done event while stopped changes nothing
                if (mdl_run) begin
                    mdl_samples[mdl_cur] = samp;
                    mdl_flags[mdl_cur]   = 1'b1;
                    c     = mdl_cur;
                    found = 1'b0;
                    // The 4-bit index wraps by itself, so the current
                    // channel is visited last.
                    for (int i = 0; i < NUM_CH; i++) begin
                        c = c + 4'd1;
                        if (!found && (mdl_cont[c] || mdl_count[c] != 0)) begin
                            if (!mdl_cont[c])
                                mdl_count[c] = mdl_count[c] - 4'd1;
                            mdl_cur = c;
                            found   = 1'b1;
                        end
                    end
                    mdl_run = found;
                end
            end
            OP_QUERY: begin
                r.flag        = mdl_flags[ch];
                mdl_flags[ch] = 1'b0;
            end
            default: begin
                r.sample = mdl_samples[ch];
            end
        endcase
        r.sel  = mdl_cur;
        r.conv = mdl_run;
        return r;
    endfunction

    // Offer one input transaction and hold it until the block takes it. Bursts
    // of random length are separated by random gaps with valid dropped.
    task automatic send_item(opcode_t op, logic [CHANNEL_W-1:0] ch, logic cont,
                             logic [SAMPLE_W-1:0] samp, bit typed, scan_status_t res);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                @(negedge aclk);
                s_valid = 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge aclk);
        s_valid        = 1'b1;
        s_opcode       = op;
        s_channel      = ch;
        s_continuous   = cont;
        s_sample_value = samp;
        drv_typed      = typed;
        drv_res        = res;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic table_row(opcode_t op, logic [CHANNEL_W-1:0] ch, logic cont,
                             logic [SAMPLE_W-1:0] samp, int reps, bit typed,
                             scan_status_t res);
        scan_row_t row;
        row.op    = op;
        row.ch    = ch;
        row.cont  = cont;
        row.samp  = samp;
        row.reps  = reps;
        row.typed = typed;
        row.res   = res;
        scan_rows.push_back(row);
    endtask

    // Sample both channels at the rising edge: predict on every accepted input
    // transaction, check every accepted result against the oldest prediction.
    always @(posedge aclk) begin
        scan_status_t predicted;
        scan_status_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                if (!(opcode_t'(s_opcode) == OP_DONE && !mdl_run))
                    effective_items++;
                predicted = predict_scan(opcode_t'(s_opcode), s_channel, s_continuous,
                                         s_sample_value);
                scan_status_q.push_back(drv_typed ? drv_res : predicted);
            end
            if (m_valid && m_ready) begin
                if (scan_status_q.size() == 0) begin
                    $error("result transaction with nothing expected");
                    mismatches++;
                end else begin
                    want = scan_status_q.pop_front();
                    if (m_selected_channel !== want.sel) begin
                        $error("selected_channel: expected %0d, got %0d",
                               want.sel, m_selected_channel);
                        mismatches++;
                    end
                    if (m_converting !== want.conv) begin
                        $error("converting: expected %0d, got %0d",
                               want.conv, m_converting);
                        mismatches++;
                    end
                    if (m_done_flag !== want.flag) begin
                        $error("done_flag: expected %0d, got %0d",
                               want.flag, m_done_flag);
                        mismatches++;
                    end
                    if (m_stored_sample !== want.sample) begin
                        $error("stored_sample: expected 0x%03h, got 0x%03h",
                               want.sample, m_stored_sample);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Receiver: its own rotating stall pattern, plus one long hold-off once
    // traffic is under way so that the block backs up into its input.
    initial begin
        int  rx_cycle;
        int  hold_left;
        bit  hold_done;
        rx_cycle  = 0;
        hold_left = 0;
        hold_done = 1'b0;
        m_ready   = 1'b0;
        forever begin
            @(negedge aclk);
            rx_cycle++;
            if (!hold_done && effective_items >= 250) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready = 1'b0;
            end else begin
                case ((rx_cycle / 50) % 4)
                    0: m_ready = 1'b1;
                    1: m_ready = (rx_cycle % 4) != 0;
                    2: m_ready = $urandom_range(0, 1);
                    default: m_ready = ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Watchdog: give up if the run overruns its budget
    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        scan_status_t none;
        int           base;
        int           seg;
        int           n;
        logic [3:0]   hot_ch;
        opcode_t      op;

        none           = '0;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_opcode       = OP_REQUEST;
        s_channel      = '0;
        s_continuous   = 1'b0;
        s_sample_value = '0;
        drv_typed      = 1'b0;
        drv_res        = '0;
        for (int i = 0; i < NUM_CH; i++) begin
            mdl_samples[i] = '0;
            mdl_flags[i]   = 1'b0;
            mdl_count[i]   = '0;
            mdl_cont[i]    = 1'b0;
        end
        mdl_cur = '0;
        mdl_run = 1'b0;

        // Hold reset, then release it on a falling edge
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed table. Results straight after reset are typed in; the
        // rest fall to the predictor.
        table_row(OP_QUERY,   4'd0,  1'b0, 12'h000, 1, 1'b1, '{4'd0, 1'b0, 1'b0, 12'h000});
        table_row(OP_READ,    4'd15, 1'b1, 12'hfff, 1, 1'b1, '{4'd0, 1'b0, 1'b0, 12'h000});
        // done event while stopped is ignored
        table_row(OP_DONE,    4'd15, 1'b1, 12'hfff, 1, 1'b1, '{4'd0, 1'b0, 1'b0, 12'h000});
        table_row(OP_REQUEST, 4'd15, 1'b1, 12'h000, 1, 1'b1, '{4'd15, 1'b1, 1'b0, 12'h000});
        // search wraps right round back to the continuous channel
        table_row(OP_DONE,    4'd0,  1'b0, 12'hfff, 1, 1'b0, none);
        // single request on a continuous channel
        table_row(OP_REQUEST, 4'd15, 1'b0, 12'h000, 1, 1'b0, none);
        // count saturates at the limit
        table_row(OP_REQUEST, 4'd0,  1'b0, 12'h555, 16, 1'b0, none);
        // continuous request clears the count, then back to one single
        table_row(OP_REQUEST, 4'd0,  1'b1, 12'h000, 1, 1'b0, none);
        table_row(OP_REQUEST, 4'd0,  1'b0, 12'h000, 1, 1'b0, none);
        // drain both channels until no channel is left and the converter stops
        table_row(OP_DONE,    4'd7,  1'b1, 12'h000, 1, 1'b0, none);
        table_row(OP_DONE,    4'd8,  1'b0, 12'ha5a, 1, 1'b0, none);
        table_row(OP_DONE,    4'd0,  1'b1, 12'h5a5, 1, 1'b0, none);
        table_row(OP_QUERY,   4'd15, 1'b0, 12'h000, 1, 1'b0, none);
        table_row(OP_QUERY,   4'd15, 1'b1, 12'hfff, 1, 1'b0, none);
        table_row(OP_READ,    4'd0,  1'b0, 12'h000, 1, 1'b0, none);
        table_row(OP_READ,    4'd15, 1'b0, 12'h000, 1, 1'b0, none);

        foreach (scan_rows[r])
            for (int k = 0; k < scan_rows[r].reps; k++)
                send_item(scan_rows[r].op, scan_rows[r].ch, scan_rows[r].cont,
                          scan_rows[r].samp, scan_rows[r].typed, scan_rows[r].res);

        // Random part in segments. Most are well-formed: requests, then a run
        // of conversion-done events, then flag queries and sample reads.
        base = effective_items;
        while (effective_items - base < RAND_ITEMS) begin
            seg = $urandom_range(0, 9);
            if (seg == 0) begin
                // noise: any field, any value
                n = $urandom_range(1, 5);
                repeat (n)
                    send_item(opcode_t'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                              1'($urandom_range(0, 1)), 12'($urandom), 1'b0, none);
            end else if (seg == 1) begin
                // hammer one channel with singles until its count saturates
                hot_ch = 4'($urandom_range(0, 15));
                repeat (17)
                    send_item(OP_REQUEST, hot_ch, 1'b0, 12'($urandom), 1'b0, none);
            end else begin
                n = $urandom_range(1, 3);
                repeat (n)
                    send_item(OP_REQUEST, 4'($urandom_range(0, 15)),
                              ($urandom_range(0, 9) < 3), 12'($urandom), 1'b0, none);
                n = $urandom_range(1, 8);
                repeat (n)
                    send_item(OP_DONE, 4'($urandom_range(0, 15)),
                              1'($urandom_range(0, 1)), 12'($urandom), 1'b0, none);
                n = $urandom_range(1, 4);
                repeat (n) begin
                    op = $urandom_range(0, 1) ? OP_QUERY : OP_READ;
                    send_item(op, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                              12'($urandom), 1'b0, none);
                end
            end
        end

        // Drop valid, wait for every outstanding result, then let the
        // pipeline settle so that stray results are caught.
        @(negedge aclk);
        s_valid = 1'b0;
        while (scan_status_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (scan_status_q.size() != 0) begin
            $error("%0d expected results never arrived", scan_status_q.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
